[sv/ffra_pkg.sv]
package ffra_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_RD,
    ST_LD,
    ST_SCAN,
    ST_MASK,
    ST_MRD,
    ST_MLD,
    ST_DONE
  } state_t;

  localparam logic REQ_PLACE = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam int FIELD_W = 9;
  localparam int CORNER_W = 8;
  localparam logic [FIELD_W-1:0] SIDE_RESET = 9'd256;

  // column lane controls
  typedef struct packed {
    logic clear;
    logic load;
  } lane_ctl_t;

endpackage

[sv/first_fit_rect_allocator_core.sv]
// First-fit rectangle allocator on a square occupancy grid.
// Input channel: in_valid/in_stall with in_req_type, in_rect_width, in_rect_height.
//   A place item searches corners row by row, then column by column, for the
//   first rectangle that is fully free inside the side in use, and marks it.
//   A clear item empties the whole grid.
// Result channel: out_valid/out_stall with out_placed, out_corner_x, out_corner_y;
//   exactly one result per item, in order.
// cfg_we/cfg_data write side_length (values above MAX_SIDE act as MAX_SIDE).
// One item at a time: in_stall is high from acceptance until the result is in
// the output register. Steps per item:
//   clear item: the whole grid is cleared, one grid row written per cycle.
//   trivial place (zero size, no fit by size, zero side): straight to finish.
//   search: each grid row up to the hit is read (ST_RD) and loaded into the
//   column counters (ST_LD); once h rows are in, the s columns are scanned, one
//   column per cycle; on a hit the column mask is built and each rectangle
//   row is read and written back marked (ST_MRD, ST_MLD), then ST_DONE.
// Reset: a clearing pass writes all MAX_SIDE rows with in_stall high;
// side_length returns to 256.
// Out stall: the result holds in its register; the next item may be accepted,
// and its result waits in ST_DONE until the register is free.
module first_fit_rect_allocator_core #(
  parameter int MAX_SIDE = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ffra_pkg::FIELD_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [ffra_pkg::FIELD_W-1:0]  in_rect_width,
  input  logic [ffra_pkg::FIELD_W-1:0]  in_rect_height,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_placed,
  output logic [ffra_pkg::CORNER_W-1:0] out_corner_x,
  output logic [ffra_pkg::CORNER_W-1:0] out_corner_y
);
  import ffra_pkg::*;

  localparam int AW = $clog2(MAX_SIDE);
  localparam int CW = $clog2(MAX_SIDE + 1);
  localparam int LW = (CW > FIELD_W) ? CW : FIELD_W;

  state_t state_r, state_nxt;

  logic [FIELD_W-1:0]  side_r;
  logic [LW-1:0]       s_r;       // side in use, latched per item
  logic [LW-1:0]       w_r, h_r;
  logic [LW-1:0]       row_r;     // row counter: clear, search and mark
  logic [LW-1:0]       x_r;
  logic [LW-1:0]       run_r;     // horizontal run of fitting columns
  logic [LW-1:0]       cx_r, cy_r;
  logic                res_ok_r;
  logic                clr_req_r;
  logic [MAX_SIDE-1:0] mask_r;

  logic                out_valid_r, out_placed_r;
  logic [CORNER_W-1:0] out_cx_r, out_cy_r;

  logic [LW-1:0]       used_side;
  logic [LW-1:0]       in_w, in_h;
  logic                in_acc, out_acc, out_free;
  logic [MAX_SIDE-1:0] rdata, ok;
  logic [MAX_SIDE-1:0] mem_wdata;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  lane_ctl_t           lane_ctl;
  logic [LW-1:0]       run_nxt;
  logic                hit, last_x, last_row, rows_in, clr_last, mark_last;

  assign used_side = (LW'(side_r) > LW'(MAX_SIDE)) ? LW'(MAX_SIDE) : LW'(side_r);
  assign in_w      = LW'(in_rect_width);
  assign in_h      = LW'(in_rect_height);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // scan step: one column per cycle
  assign run_nxt   = ok[x_r[AW-1:0]] ? run_r + LW'(1) : '0;
  assign hit       = (run_nxt == w_r);
  assign last_x    = (x_r + LW'(1) == s_r);
  assign last_row  = (row_r + LW'(1) == s_r);
  assign rows_in   = (row_r + LW'(1) >= h_r);
  assign clr_last  = (row_r == LW'(MAX_SIDE - 1));
  assign mark_last = (row_r + LW'(1) == cy_r + h_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_CLEAR) begin
            state_nxt = ST_CLR;
          end else if (used_side == '0 || in_w == '0 || in_h == '0 ||
                       in_w > used_side || in_h > used_side) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_CLR:  if (clr_last) state_nxt = clr_req_r ? ST_DONE : ST_IDLE;
      ST_RD:   state_nxt = ST_LD;
      ST_LD:   state_nxt = rows_in ? ST_SCAN : ST_RD;
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_MASK;
        end else if (last_x) begin
          state_nxt = last_row ? ST_DONE : ST_RD;
        end
      end
      ST_MASK: state_nxt = ST_MRD;
      ST_MRD:  state_nxt = ST_MLD;
      ST_MLD:  state_nxt = mark_last ? ST_DONE : ST_MRD;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory and lane controls
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = row_r[AW-1:0];
    mem_raddr = row_r[AW-1:0];
    mem_wdata = '0;
    lane_ctl  = '{clear: 1'b0, load: 1'b0};
    case (state_r)
      ST_IDLE: lane_ctl.clear = in_acc;
      ST_CLR:  mem_we = 1'b1;
      ST_RD:   mem_re = 1'b1;
      ST_LD:   lane_ctl.load = 1'b1;
      ST_MRD:  mem_re = 1'b1;
      ST_MLD: begin
        mem_we    = 1'b1;
        mem_wdata = rdata | mask_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      row_r     <= '0;
      clr_req_r <= 1'b0;
      side_r    <= SIDE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) side_r <= cfg_data;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            s_r       <= used_side;
            w_r       <= in_w;
            h_r       <= in_h;
            row_r     <= '0;
            cx_r      <= '0;
            cy_r      <= '0;
            clr_req_r <= (in_req_type == REQ_CLEAR);
            // zero size fits at the origin when the side is nonzero
            res_ok_r  <= (in_req_type == REQ_CLEAR) ||
                         (used_side != '0 && (in_w == '0 || in_h == '0));
          end
        end
        ST_CLR:  row_r <= row_r + LW'(1);
        ST_LD: begin
          x_r   <= '0;
          run_r <= '0;
        end
        ST_SCAN: begin
          run_r <= run_nxt;
          x_r   <= x_r + LW'(1);
          if (hit) begin
            cx_r     <= x_r + LW'(1) - w_r;
            cy_r     <= row_r + LW'(1) - h_r;
            row_r    <= row_r + LW'(1) - h_r;
            res_ok_r <= 1'b1;
          end else if (last_x) begin
            row_r <= row_r + LW'(1);
          end
        end
        ST_MLD:  row_r <= row_r + LW'(1);
        default: ;
      endcase
      if (state_r == ST_LD && !rows_in) row_r <= row_r + LW'(1);
    end
  end

  // rectangle column mask, one compare pair per column
  for (genvar i = 0; i < MAX_SIDE; i++) begin : g_mask
    always_ff @(posedge clk) begin
      if (state_r == ST_MASK) begin
        mask_r[i] <= (LW'(i) >= cx_r) && (LW'(i) < cx_r + w_r);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_placed_r <= res_ok_r;
      out_cx_r     <= res_ok_r ? cx_r[CORNER_W-1:0] : '0;
      out_cy_r     <= res_ok_r ? cy_r[CORNER_W-1:0] : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_placed   = out_placed_r;
  assign out_corner_x = out_cx_r;
  assign out_corner_y = out_cy_r;

  ffra_grid_mem #(.MAX_SIDE(MAX_SIDE), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  ffra_col_lanes #(.MAX_SIDE(MAX_SIDE), .CW(CW), .LW(LW)) u_lanes (
    .clk      (clk),
    .ctl      (lane_ctl),
    .row_bits (rdata),
    .side     (s_r),
    .height   (h_r),
    .ok       (ok)
  );

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside finish state");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLR || state_r == ST_MLD))
    else $error("grid written outside clear or mark");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> (x_r < s_r && row_r < s_r))
    else $error("scan beyond side in use");

  a_mark_inside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MLD |-> (row_r >= cy_r && row_r < cy_r + h_r))
    else $error("mark row outside rectangle");

endmodule

[sv/ffra_grid_mem.sv]
module ffra_grid_mem #(
  parameter int MAX_SIDE = 256,
  parameter int AW = $clog2(MAX_SIDE)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [MAX_SIDE-1:0] wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output logic [MAX_SIDE-1:0] rdata
);

  logic [MAX_SIDE-1:0] mem [MAX_SIDE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/ffra_col_lanes.sv]
module ffra_col_lanes #(
  parameter int MAX_SIDE = 256,
  parameter int CW = $clog2(MAX_SIDE + 1),
  parameter int LW = 9
) (
  input  logic                clk,
  input  ffra_pkg::lane_ctl_t ctl,
  input  logic [MAX_SIDE-1:0] row_bits,
  input  logic [LW-1:0]       side,
  input  logic [LW-1:0]       height,
  output logic [MAX_SIDE-1:0] ok
);
  import ffra_pkg::*;

  // per column: count of free cells in a vertical run ending at the last row loaded
  logic [CW-1:0] run_r [MAX_SIDE];

  for (genvar i = 0; i < MAX_SIDE; i++) begin : g_lane
    logic outside;
    assign outside = (LW'(i) >= side);

    always_ff @(posedge clk) begin
      if (ctl.clear) begin
        run_r[i] <= '0;
      end else if (ctl.load) begin
        run_r[i] <= (row_bits[i] || outside) ? '0 : run_r[i] + CW'(1);
      end
    end

    assign ok[i] = (LW'(run_r[i]) >= height) && !outside;
  end

endmodule
